// ===== sv/keypad_matrix_poll_top_assert.svh =====
// ----------------------------------------------------------------------------
// keypad_matrix_poll_top_assert.svh
// Assertion macros for the keypad poll RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_MATRIX_POLL_TOP_ASSERT_SVH
`define KEYPAD_MATRIX_POLL_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define KMP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KMP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define KMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Constants, types and register indexes of the keypad matrix poll block.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int NUM_COLUMNS = 6;
  localparam int NUM_ROWS    = 4;
  localparam int COL_FIELDS  = 6;
  localparam int ROW_LIMIT   = 4;
  localparam int SCAN_COLS   = (NUM_COLUMNS < COL_FIELDS) ? NUM_COLUMNS : COL_FIELDS;
  localparam int SCAN_ROWS   = (NUM_ROWS < ROW_LIMIT) ? NUM_ROWS : ROW_LIMIT;
  localparam int NO_KEY      = NUM_COLUMNS * NUM_ROWS;

  localparam int ROW_W      = 8;
  localparam int KEY_W      = $clog2(NO_KEY + 1);
  localparam int MASK_W     = NO_KEY;
  localparam int MASK_IDX_W = (NO_KEY > 1) ? $clog2(NO_KEY) : 1;
  localparam int SUPPLY_W   = 12;
  localparam int PERIOD_W   = 8;
  localparam int DELAY_W    = 10;
  localparam int ELAPSED_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [KEY_W-1:0]     KEY_NONE      = KEY_W'(NO_KEY);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [SUPPLY_W-1:0]  THR_RESET     = SUPPLY_W'(2048);
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(30);
  localparam logic [DELAY_W-1:0]   DELAY_RESET   = DELAY_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY_THR  = 3'd0,
    CFG_POLL_PERIOD = 3'd1,
    CFG_LOSS_DELAY  = 3'd2,
    CFG_ERR_MASK    = 3'd3,
    CFG_SILENT_MASK = 3'd4
  } cfg_idx_e;

  typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== sv/kmp_scan.sv =====
// ----------------------------------------------------------------------------
// kmp_scan
// Priority scan of the column readback bytes into a key index.
// ----------------------------------------------------------------------------
module kmp_scan (
  input  kmp_pkg::row_t               rows_i [kmp_pkg::COL_FIELDS],
  output logic [kmp_pkg::KEY_W-1:0]   key_o
);
  import kmp_pkg::*;

  // lowest matching column wins: walk from the top down and overwrite
  always_comb begin
    key_o = KEY_NONE;
    for (int c = SCAN_COLS - 1; c >= 0; c--) begin
      for (int r = SCAN_ROWS - 1; r >= 0; r--) begin
        if (rows_i[c] == (row_t'(1) << r)) begin
          key_o = KEY_W'((NUM_COLUMNS - 1 - c) * NUM_ROWS + r);
        end
      end
    end
  end

endmodule

// ===== sv/keypad_matrix_poll_top.sv =====
// Pipeline: a result word passes the input register, then the result register;
// a receiver stall can hold it in either register.
// Throughput: one poll word per cycle while the receiver is not stalling.
// Reset: rst_ni clears the pipeline valids, last key (no key), loss timer
// and loads the register defaults (threshold 2048, 30 ms, 200 ms, masks 0).
// ----------------------------------------------------------------------------
// keypad_matrix_poll_top
// Keypad matrix poll with key event detection and supply loss alarm.
// ----------------------------------------------------------------------------
`include "keypad_matrix_poll_top_assert.svh"

module keypad_matrix_poll_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col0_i,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col1_i,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col2_i,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col3_i,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col4_i,
  input  logic [kmp_pkg::ROW_W-1:0]         rows_col5_i,
  input  logic                              keypad_enabled_i,
  input  logic                              power_fail_i,
  input  logic                              error_present_i,
  input  logic [kmp_pkg::SUPPLY_W-1:0]      supply_level_i,
  input  logic                              aux_present_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              key_event_o,
  output logic [kmp_pkg::KEY_W-1:0]         key_index_o,
  output logic                              beep_start_o,
  output logic                              loss_alarm_o
);
  import kmp_pkg::*;

  logic [SUPPLY_W-1:0]  thr_q;
  logic [PERIOD_W-1:0]  period_q;
  logic [DELAY_W-1:0]   delay_q;
  logic [MASK_W-1:0]    err_mask_q;
  logic [MASK_W-1:0]    silent_mask_q;

  logic                 s1_valid_q;
  row_t                 s1_rows_q [COL_FIELDS];
  logic                 s1_en_q;
  logic                 s1_pfail_q;
  logic                 s1_err_q;
  logic [SUPPLY_W-1:0]  s1_supply_q;
  logic                 s1_aux_q;

  logic [KEY_W-1:0]     last_key_q, last_key_d;
  logic                 armed_q, armed_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;

  logic                 out_valid_q;
  logic                 event_q, event_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic                 beep_q, beep_d;
  logic                 alarm_q, alarm_d;

  logic                 s1_adv;
  logic [KEY_W-1:0]     scan_key;
  logic                 scan_en;
  logic                 key_valid;
  logic                 allow_bit;
  logic                 silent_bit;
  logic                 supply_low;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= THR_RESET;
      period_q      <= PERIOD_RESET;
      delay_q       <= DELAY_RESET;
      err_mask_q    <= '0;
      silent_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SUPPLY_THR:  thr_q         <= cfg_wdata_i[SUPPLY_W-1:0];
        CFG_POLL_PERIOD: period_q      <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_LOSS_DELAY:  delay_q       <= cfg_wdata_i[DELAY_W-1:0];
        CFG_ERR_MASK:    err_mask_q    <= cfg_wdata_i[MASK_W-1:0];
        CFG_SILENT_MASK: silent_mask_q <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_rows_q[0] <= rows_col0_i;
      s1_rows_q[1] <= rows_col1_i;
      s1_rows_q[2] <= rows_col2_i;
      s1_rows_q[3] <= rows_col3_i;
      s1_rows_q[4] <= rows_col4_i;
      s1_rows_q[5] <= rows_col5_i;
      s1_en_q      <= keypad_enabled_i;
      s1_pfail_q   <= power_fail_i;
      s1_err_q     <= error_present_i;
      s1_supply_q  <= supply_level_i;
      s1_aux_q     <= aux_present_i;
    end
  end

  kmp_scan u_scan (
    .rows_i (s1_rows_q),
    .key_o  (scan_key)
  );

  assign scan_en    = s1_en_q && !s1_pfail_q;
  assign key_valid  = scan_key < KEY_NONE;
  assign allow_bit  = key_valid && err_mask_q[scan_key[MASK_IDX_W-1:0]];
  assign silent_bit = key_valid && silent_mask_q[scan_key[MASK_IDX_W-1:0]];
  assign supply_low = (s1_supply_q <= thr_q) && s1_aux_q;

  assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(period_q);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];

  always_comb begin
    last_key_d = last_key_q;
    armed_d    = armed_q;
    elapsed_d  = elapsed_q;
    event_d    = 1'b0;
    key_d      = KEY_NONE;
    beep_d     = 1'b0;
    alarm_d    = 1'b0;
    if (scan_en && scan_key != last_key_q) begin
      last_key_d = scan_key;
      if (key_valid && (!s1_err_q || allow_bit)) begin
        event_d = 1'b1;
        key_d   = scan_key;
        beep_d  = !silent_bit;
      end
    end
    if (!s1_pfail_q) begin
      if (supply_low) begin
        armed_d = 1'b1;
        if (!armed_q) begin
          elapsed_d = '0;
        end else begin
          elapsed_d = elapsed_sat;
          alarm_d   = elapsed_sat > ELAPSED_W'(delay_q);
        end
      end else begin
        armed_d = 1'b0;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q  <= KEY_NONE;
      armed_q     <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        last_key_q <= last_key_d;
        armed_q    <= armed_d;
        elapsed_q  <= elapsed_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      event_q <= event_d;
      key_q   <= key_d;
      beep_q  <= beep_d;
      alarm_q <= alarm_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_event_o  = event_q;
  assign key_index_o  = key_q;
  assign beep_start_o = beep_q;
  assign loss_alarm_o = alarm_q;

  `KMP_ASSERT_IMPLIES(a_no_event_no_key, clk_i, rst_ni,
    out_valid_o && !key_event_o, key_index_o == KEY_NONE && !beep_start_o)
  `KMP_ASSERT_IMPLIES(a_event_tracks_last, clk_i, rst_ni,
    out_valid_o && key_event_o, last_key_q == key_index_o)
  `KMP_ASSERT_IMPLIES(a_alarm_needs_armed, clk_i, rst_ni,
    out_valid_o && loss_alarm_o, armed_q)
  `KMP_ASSERT_IMPLIES(a_stall_means_full, clk_i, rst_ni,
    !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `KMP_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni,
    s1_adv, out_valid_q)

endmodule

// ===== test/keypad_matrix_poll_top_test.sv =====
// ----------------------------------------------------------------------------
// keypad_matrix_poll_top_test
// Drives poll words through the keypad scanner and checks every result word
// against an in-bench predictor of the key scan, key events, beep decision and
// supply loss timer. A short directed sequence comes first. Random phases
// follow under several register settings and different sender/receiver stall
// mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module keypad_matrix_poll_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  typedef struct packed {
    row_t [COL_FIELDS-1:0]  rows;
    logic                   enabled;
    logic                   pfail;
    logic                   err;
    logic [SUPPLY_W-1:0]    supply;
    logic                   aux;
  } poll_word_t;

  typedef struct packed {
    logic             key_event;
    logic [KEY_W-1:0] key_index;
    logic             beep;
    logic             alarm;
  } key_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  key_event_o;
  logic [KEY_W-1:0]      key_index_o;
  logic                  beep_start_o;
  logic                  loss_alarm_o;
  logic [ROW_W-1:0]      rows_col0_i, rows_col1_i, rows_col2_i;
  logic [ROW_W-1:0]      rows_col3_i, rows_col4_i, rows_col5_i;
  logic                  keypad_enabled_i, power_fail_i, error_present_i, aux_present_i;
  logic [SUPPLY_W-1:0]   supply_level_i;

  poll_word_t  drv_word = '0;
  poll_word_t  poll_q[$];
  key_result_t expect_q[$];
  logic        in_taken = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_len = 0;
  int          fail_cnt = 0;
  int          n_words = 0;
  int          n_events = 0;
  int          n_beeps = 0;
  int          n_alarms = 0;
  int          n_settings = 1;
  row_t [COL_FIELDS-1:0] held_rows = '0;

  // register mirror and scanner state
  logic [SUPPLY_W-1:0]   thr_cfg = THR_RESET;
  logic [PERIOD_W-1:0]   period_cfg = PERIOD_RESET;
  logic [DELAY_W-1:0]    delay_cfg = DELAY_RESET;
  logic [MASK_W-1:0]     allow_mask_cfg = '0;
  logic [MASK_W-1:0]     silent_mask_cfg = '0;
  logic [KEY_W-1:0]      prev_key = KEY_NONE;
  logic                  loss_armed = 1'b0;
  logic [ELAPSED_W-1:0]  elapsed_ms = '0;

  assign rows_col0_i      = drv_word.rows[0];
  assign rows_col1_i      = drv_word.rows[1];
  assign rows_col2_i      = drv_word.rows[2];
  assign rows_col3_i      = drv_word.rows[3];
  assign rows_col4_i      = drv_word.rows[4];
  assign rows_col5_i      = drv_word.rows[5];
  assign keypad_enabled_i = drv_word.enabled;
  assign power_fail_i     = drv_word.pfail;
  assign error_present_i  = drv_word.err;
  assign supply_level_i   = drv_word.supply;
  assign aux_present_i    = drv_word.aux;

  keypad_matrix_poll_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rows_col0_i     (rows_col0_i),
    .rows_col1_i     (rows_col1_i),
    .rows_col2_i     (rows_col2_i),
    .rows_col3_i     (rows_col3_i),
    .rows_col4_i     (rows_col4_i),
    .rows_col5_i     (rows_col5_i),
    .keypad_enabled_i(keypad_enabled_i),
    .power_fail_i    (power_fail_i),
    .error_present_i (error_present_i),
    .supply_level_i  (supply_level_i),
    .aux_present_i   (aux_present_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_event_o     (key_event_o),
    .key_index_o     (key_index_o),
    .beep_start_o    (beep_start_o),
    .loss_alarm_o    (loss_alarm_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic key_result_t predict_tick(poll_word_t w);
    key_result_t        r;
    logic [KEY_W-1:0]   key;
    logic [ELAPSED_W:0] sum;
    bit                 hit;
    r = '0;
    r.key_index = KEY_NONE;
    key = KEY_NONE;
    hit = 1'b0;
    for (int c = 0; c < SCAN_COLS; c++) begin
      for (int k = 0; k < SCAN_ROWS; k++) begin
        if (!hit && w.rows[c] == row_t'(1 << k)) begin
          hit = 1'b1;
          key = KEY_W'((NUM_COLUMNS - 1 - c) * NUM_ROWS + k);
        end
      end
    end
    if (w.enabled && !w.pfail && key != prev_key) begin
      prev_key = key;
      if (key != KEY_NONE && (!w.err || allow_mask_cfg[key])) begin
        r.key_event = 1'b1;
        r.key_index = key;
        r.beep = !silent_mask_cfg[key];
      end
    end
    if (!w.pfail) begin
      if (w.supply <= thr_cfg && w.aux) begin
        if (!loss_armed) begin
          loss_armed = 1'b1;
          elapsed_ms = '0;
        end else begin
          sum = {1'b0, elapsed_ms} + (ELAPSED_W + 1)'(period_cfg);
          elapsed_ms = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
          r.alarm = elapsed_ms > ELAPSED_W'(delay_cfg);
        end
      end else begin
        loss_armed = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic row_t idle_byte();
    row_t b;
    case ($urandom_range(0, 3))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = row_t'(8'h10 << $urandom_range(0, 3));
      default: begin
        do b = row_t'($urandom_range(0, 255));
        while (b == 8'h01 || b == 8'h02 || b == 8'h04 || b == 8'h08);
      end
    endcase
    return b;
  endfunction

  task automatic add_tick(logic [47:0] rows, bit en, bit pf, bit er, int sup, bit aux);
    poll_word_t w;
    w.rows    = rows;
    w.enabled = en;
    w.pfail   = pf;
    w.err     = er;
    w.supply  = SUPPLY_W'(sup);
    w.aux     = aux;
    poll_q.push_back(w);
  endtask

  task automatic add_random_tick();
    poll_word_t w;
    int sel, c, s;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      w.rows = held_rows;
    end else if (sel < 75) begin
      c = $urandom_range(0, COL_FIELDS - 1);
      for (int i = 0; i < COL_FIELDS; i++)
        w.rows[i] = (i < c) ? idle_byte() : row_t'($urandom_range(0, 255));
      w.rows[c] = row_t'(1 << $urandom_range(0, SCAN_ROWS - 1));
    end else if (sel < 88) begin
      for (int i = 0; i < COL_FIELDS; i++) w.rows[i] = idle_byte();
    end else begin
      for (int i = 0; i < COL_FIELDS; i++) w.rows[i] = row_t'($urandom_range(0, 255));
    end
    held_rows = w.rows;
    w.enabled = ($urandom_range(0, 9) != 0);
    w.pfail   = ($urandom_range(0, 14) == 0);
    w.err     = ($urandom_range(0, 3) == 0);
    w.aux     = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0, 1: begin
        s = int'(thr_cfg) + int'($urandom_range(0, 6)) - 3;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
        w.supply = SUPPLY_W'(s);
      end
      2: w.supply = SUPPLY_W'($urandom_range(0, 4095));
      default: w.supply = $urandom_range(0, 1) ? '1 : '0;
    endcase
    poll_q.push_back(w);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_SUPPLY_THR:  thr_cfg = data[SUPPLY_W-1:0];
      CFG_POLL_PERIOD: period_cfg = data[PERIOD_W-1:0];
      CFG_LOSS_DELAY:  delay_cfg = data[DELAY_W-1:0];
      CFG_ERR_MASK:    allow_mask_cfg = data[MASK_W-1:0];
      CFG_SILENT_MASK: silent_mask_cfg = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int sel);
    case (sel)
      0: begin
        write_reg(CFG_SUPPLY_THR, 24'd4095);
        write_reg(CFG_POLL_PERIOD, 24'd255);
        write_reg(CFG_LOSS_DELAY, 24'd1023);
        write_reg(CFG_ERR_MASK, 24'hFFFFFF);
        write_reg(CFG_SILENT_MASK, 24'h000000);
      end
      2: begin
        write_reg(CFG_SUPPLY_THR, 24'd0);
        write_reg(CFG_POLL_PERIOD, 24'd1);
        write_reg(CFG_LOSS_DELAY, 24'd0);
        write_reg(CFG_ERR_MASK, 24'h000000);
        write_reg(CFG_SILENT_MASK, 24'hFFFFFF);
      end
      default: begin
        write_reg(CFG_SUPPLY_THR, CFG_DATA_W'($urandom_range(0, 4095)));
        write_reg(CFG_POLL_PERIOD, CFG_DATA_W'($urandom_range(1, 255)));
        write_reg(CFG_LOSS_DELAY, CFG_DATA_W'($urandom_range(0, 1023)));
        write_reg(CFG_ERR_MASK, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_SILENT_MASK, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
      end
    endcase
    n_settings++;
  endtask

  task automatic wait_drained();
    while (poll_q.size() != 0 || in_valid_i || expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string fld, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      fail_cnt++;
    end
  endtask

  // driver: hold the word until accepted, then advance or idle
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && poll_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drv_word   <= poll_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      out_ready_i <= 1'b0;
      hold_len    <= hold_len - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // monitor: check delivered results, then predict the accepted word
  always @(posedge clk_i) begin
    key_result_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result word, key_event %0b key_index %0d", $time,
                 key_event_o, key_index_o);
        fail_cnt++;
      end else begin
        want = expect_q.pop_front();
        check_field("key_event", want.key_event, key_event_o);
        check_field("key_index", want.key_index, key_index_o);
        check_field("beep_start", want.beep, beep_start_o);
        check_field("loss_alarm", want.alarm, loss_alarm_o);
        n_events += int'(want.key_event);
        n_beeps  += int'(want.beep);
        n_alarms += int'(want.alarm);
      end
    end
    if (in_valid_i && in_ready_o) begin
      expect_q.push_back(predict_tick(drv_word));
      n_words++;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: scan order, event rules and the loss timer
    add_tick(48'h000000000000, 1, 0, 0, 100, 1);
    add_tick(48'h000000000001, 1, 0, 0, 100, 1);
    add_tick(48'h000000000001, 1, 0, 0, 100, 1);
    add_tick(48'h080000000000, 1, 0, 0, 100, 1);
    add_tick(48'h000000041003, 1, 0, 0, 100, 1);
    add_tick(48'hFFFFFFFFFFFF, 1, 0, 0, 100, 1);
    add_tick(48'h000000000002, 0, 0, 0, 100, 1);
    add_tick(48'h000000000002, 1, 1, 0, 100, 1);
    add_tick(48'h000000000004, 1, 0, 1, 100, 1);
    add_tick(48'h000000000004, 1, 0, 0, 2048, 1);
    add_tick(48'h000000000000, 1, 0, 0, 2049, 1);
    add_tick(48'h000000000800, 1, 0, 0, 0, 0);
    add_tick(48'h204080000000, 1, 0, 0, 0, 1);
    wait_drained();

    write_reg(CFG_SUPPLY_THR, 24'd0);
    write_reg(CFG_POLL_PERIOD, 24'd255);
    write_reg(CFG_LOSS_DELAY, 24'd0);
    write_reg(CFG_ERR_MASK, 24'hFFFFFF);
    write_reg(CFG_SILENT_MASK, 24'h555555);
    n_settings++;
    add_tick(48'h000000000001, 1, 0, 1, 0, 1);
    add_tick(48'h000000000002, 1, 0, 1, 0, 1);
    add_tick(48'h010000000000, 1, 0, 0, 1, 1);
    add_tick(48'h000000000008, 1, 0, 0, 4095, 1);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      apply_config(p);
      @(posedge clk_i);
      case (p / 2)
        0: begin tx_idle_pct = 10; rx_stall_pct = 61; end
        1: begin tx_idle_pct = 61; rx_stall_pct = 10; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      if (p == 0) hold_len = 250;
      for (int n = 0; n < 305; n++) add_random_tick();
    end
    wait_drained();

    $display("Covered %0d poll words: %0d key events, %0d with beep, %0d loss alarm ticks,",
             n_words, n_events, n_beeps, n_alarms);
    $display("across %0d register settings with sender gaps and receiver stalls.",
             n_settings);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d results still outstanding", expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/kmp_pkg.sv
sv/kmp_scan.sv
sv/keypad_matrix_poll_top.sv
test/keypad_matrix_poll_top_test.sv
